// ===== src/nearest_box_along_axis_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the nearest box along axis block
// Same-cycle and next-cycle implication checks, gated by reset.
// ---------------------------------------------------------------------------
`ifndef NEAREST_BOX_ALONG_AXIS_ASSERT_SVH
`define NEAREST_BOX_ALONG_AXIS_ASSERT_SVH

`define NBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define NBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nba_pkg.sv =====
// ---------------------------------------------------------------------------
// nba_pkg
// Shared types and constants of the nearest box along axis block.
// ---------------------------------------------------------------------------
package nba_pkg;

    localparam int CENTER_W    = 24;
    localparam int SCALE_W     = 16;
    localparam int FIELD_ID_W  = 16;
    localparam int PROD_W      = 2 * SCALE_W;
    localparam int GAP_W       = 26;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 48;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_LEFT  = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    localparam logic signed [GAP_W-1:0] GAP_MAX = {1'b0, {(GAP_W-1){1'b1}}};
    localparam logic signed [GAP_W-1:0] GAP_MIN = {1'b1, {(GAP_W-1){1'b0}}};

    typedef struct packed {
        logic                       cmd;
        logic                       last;
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [PROD_W-1:0]          prod_x;
        logic [PROD_W-1:0]          prod_y;
        logic [FIELD_ID_W-1:0]      box_id;
        logic                       trig;
        logic                       family;
        logic [1:0]                 heading;
    } t_entry;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic                    begin_q;
        logic                    last;
        logic                    qual;
        logic                    neg;
        logic signed [GAP_W-1:0] gap;
        logic [FIELD_ID_W-1:0]   id;
        logic                    trig;
    } t_judged;

    typedef struct packed {
        logic signed [GAP_W-1:0] gap;
        logic                    found;
        logic [FIELD_ID_W-1:0]   id;
        logic                    trig;
    } t_result;

    typedef struct packed {
        logic judged_valid;
        logic last_fire;
    } t_back_status;

endpackage

// ===== src/nba_front.sv =====
// ---------------------------------------------------------------------------
// nba_front
// Accepts input transactions, unpacks them and forms the scale products.
// ---------------------------------------------------------------------------
module nba_front (
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [nba_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                           i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    input  nba_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output nba_pkg::t_entry                o_entry
);
    import nba_pkg::*;

    logic [SCALE_W-1:0] w_scale_x, w_scale_y, w_box_x, w_box_y;

    assign w_scale_x = i_s_axis_tdata[63:48];
    assign w_scale_y = i_s_axis_tdata[79:64];
    assign w_box_x   = i_s_axis_tdata[95:80];
    assign w_box_y   = i_s_axis_tdata[111:96];

    assign o_s_axis_tready = !i_q_status.full;
    assign o_push          = i_s_axis_tvalid && !i_q_status.full;

    always_comb begin
        o_entry.cmd     = i_s_axis_tuser;
        o_entry.last    = i_s_axis_tlast;
        o_entry.cx      = i_s_axis_tdata[23:0];
        o_entry.cy      = i_s_axis_tdata[47:24];
        o_entry.prod_x  = w_scale_x * w_box_x;
        o_entry.prod_y  = w_scale_y * w_box_y;
        o_entry.box_id  = i_s_axis_tdata[127:112];
        o_entry.trig    = i_s_axis_tdata[128];
        o_entry.family  = i_s_axis_tdata[129];
        o_entry.heading = i_s_axis_tdata[131:130];
    end

endmodule

// ===== src/nba_queue.sv =====
// ---------------------------------------------------------------------------
// nba_queue
// Short first-in first-out queue between front and back.
// ---------------------------------------------------------------------------
module nba_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nba_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output nba_pkg::t_entry     o_head,
    output nba_pkg::t_q_status  o_status
);
    import nba_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              w_do_push, w_do_pop;

    assign w_do_push = i_push && (r_count != CntW'(DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == CntW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/nba_back.sv =====
// ---------------------------------------------------------------------------
// nba_back
// Judges each queued item against the mover, keeps the running nearest box
// and registers one result per query.
// ---------------------------------------------------------------------------
module nba_back #(
    parameter int FRAC_BITS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nba_pkg::t_entry       i_head,
    input  nba_pkg::t_q_status    i_q_status,
    output logic                  o_pop,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output nba_pkg::t_result      o_out,
    output nba_pkg::t_back_status o_status
);
    import nba_pkg::*;

    localparam int HalfW = PROD_W - (FRAC_BITS + 1);
    localparam int CalcW = ((HalfW > CENTER_W) ? HalfW : CENTER_W) + 3;
    localparam int IdW   = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
    localparam logic [CalcW-1:0] Rnd = CalcW'((64'd1 << FRAC_BITS) - 64'd1);

    function automatic logic signed [CalcW-1:0] f_whole(input logic signed [CalcW-1:0] v);
        logic signed [CalcW-1:0] adj;
        adj = v[CalcW-1] ? (v + $signed(Rnd)) : v;
        return adj >>> FRAC_BITS;
    endfunction

    // mover state
    logic signed [CENTER_W-1:0] r_mcx, r_mcy;
    logic [HalfW-1:0]           r_mhx, r_mhy;
    logic [IdW-1:0]             r_mid;
    logic [1:0]                 r_head;

    // judged stage
    logic    r_a_valid;
    t_judged r_a;
    t_judged n_a;

    // running best
    logic signed [GAP_W-1:0] r_best_gap, n_best_gap;
    logic [FIELD_ID_W-1:0]   r_best_id, n_best_id;
    logic                    r_best_trig, n_best_trig;
    logic                    r_found, n_found;

    logic    r_o_valid;
    t_result r_o;

    logic [HalfW-1:0]        w_hx, w_hy;
    logic [IdW-1:0]          w_id;
    logic                    w_along_y, w_neg;
    logic signed [CalcW-1:0] w_mc, w_mh, w_oc, w_oh, w_mpc, w_mph, w_opc, w_oph;
    logic signed [CalcW-1:0] w_ecx, w_ecy, w_ehx, w_ehy, w_emcx, w_emcy, w_emhx, w_emhy;
    logic signed [CalcW-1:0] w_diff;
    logic [CalcW-GAP_W:0]    w_diff_hi;
    logic signed [GAP_W-1:0] w_gap;
    logic                    w_overlap, w_sign_ok;
    logic                    w_out_free, w_a_fire, w_a_ready, w_load, w_closer, w_take;

    assign w_hx = HalfW'(i_head.prod_x >> (FRAC_BITS + 1));
    assign w_hy = HalfW'(i_head.prod_y >> (FRAC_BITS + 1));
    assign w_id = i_head.box_id[IdW-1:0];

    assign w_along_y = (r_head == HEAD_DOWN) || (r_head == HEAD_UP);
    assign w_neg     = (r_head == HEAD_LEFT) || (r_head == HEAD_UP);

    assign w_ecx  = CalcW'(i_head.cx);
    assign w_ecy  = CalcW'(i_head.cy);
    assign w_ehx  = $signed({{(CalcW-HalfW){1'b0}}, w_hx});
    assign w_ehy  = $signed({{(CalcW-HalfW){1'b0}}, w_hy});
    assign w_emcx = CalcW'(r_mcx);
    assign w_emcy = CalcW'(r_mcy);
    assign w_emhx = $signed({{(CalcW-HalfW){1'b0}}, r_mhx});
    assign w_emhy = $signed({{(CalcW-HalfW){1'b0}}, r_mhy});

    assign w_mc  = w_along_y ? w_emcy : w_emcx;
    assign w_mh  = w_along_y ? w_emhy : w_emhx;
    assign w_oc  = w_along_y ? w_ecy  : w_ecx;
    assign w_oh  = w_along_y ? w_ehy  : w_ehx;
    assign w_mpc = w_along_y ? w_emcx : w_emcy;
    assign w_mph = w_along_y ? w_emhx : w_emhy;
    assign w_opc = w_along_y ? w_ecx  : w_ecy;
    assign w_oph = w_along_y ? w_ehx  : w_ehy;

    assign w_overlap = (f_whole(w_mpc - w_mph) < f_whole(w_opc + w_oph)) &&
                       (f_whole(w_opc - w_oph) < f_whole(w_mpc + w_mph));

    assign w_diff    = w_neg ? ((w_oc + w_oh) - (w_mc - w_mh))
                             : ((w_oc - w_oh) - (w_mc + w_mh));
    assign w_diff_hi = w_diff[CalcW-1:GAP_W-1];

    always_comb begin
        if ((w_diff_hi == '0) || (w_diff_hi == '1)) begin
            w_gap = w_diff[GAP_W-1:0];
        end else begin
            w_gap = w_diff[CalcW-1] ? GAP_MIN : GAP_MAX;
        end
    end

    assign w_sign_ok = w_neg ? (w_gap <= 0) : (w_gap >= 0);

    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_a_fire   = r_a_valid && (!r_a.last || w_out_free);
    assign w_a_ready  = !r_a_valid || w_a_fire;
    assign w_load     = i_q_status.not_empty && w_a_ready;
    assign o_pop      = w_load;

    always_comb begin
        n_a.begin_q = (i_head.cmd == CMD_BEGIN);
        n_a.last    = i_head.last;
        n_a.qual    = (i_head.cmd == CMD_CAND) && !i_head.family && (w_id != r_mid) &&
                      w_overlap && w_sign_ok;
        n_a.neg     = (i_head.cmd == CMD_BEGIN) ?
                      ((i_head.heading == HEAD_LEFT) || (i_head.heading == HEAD_UP)) : w_neg;
        n_a.gap     = w_gap;
        n_a.id      = FIELD_ID_W'(w_id);
        n_a.trig    = i_head.trig;
    end

    assign w_closer = r_a.neg ? (r_a.gap > r_best_gap) : (r_a.gap < r_best_gap);
    assign w_take   = r_a.qual && (!r_found || w_closer);

    always_comb begin
        n_best_gap  = r_best_gap;
        n_best_id   = r_best_id;
        n_best_trig = r_best_trig;
        n_found     = r_found;
        if (r_a.begin_q) begin
            n_best_gap  = '0;
            n_best_id   = '0;
            n_best_trig = 1'b0;
            n_found     = 1'b0;
        end else if (w_take) begin
            n_best_gap  = r_a.gap;
            n_best_id   = r_a.id;
            n_best_trig = r_a.trig;
            n_found     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcx       <= '0;
            r_mcy       <= '0;
            r_mhx       <= '0;
            r_mhy       <= '0;
            r_mid       <= '0;
            r_head      <= HEAD_RIGHT;
            r_a_valid   <= 1'b0;
            r_best_gap  <= '0;
            r_best_id   <= '0;
            r_best_trig <= 1'b0;
            r_found     <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (w_load && (i_head.cmd == CMD_BEGIN)) begin
                r_mcx  <= i_head.cx;
                r_mcy  <= i_head.cy;
                r_mhx  <= w_hx;
                r_mhy  <= w_hy;
                r_mid  <= w_id;
                r_head <= i_head.heading;
            end
            if (w_a_ready) begin
                r_a_valid <= i_q_status.not_empty;
            end
            if (w_a_fire) begin
                if (r_a.last) begin
                    r_best_gap  <= '0;
                    r_best_id   <= '0;
                    r_best_trig <= 1'b0;
                    r_found     <= 1'b0;
                end else begin
                    r_best_gap  <= n_best_gap;
                    r_best_id   <= n_best_id;
                    r_best_trig <= n_best_trig;
                    r_found     <= n_found;
                end
            end
            if (w_a_fire && r_a.last) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_a <= n_a;
        end
        if (w_a_fire && r_a.last) begin
            r_o.gap   <= n_found ? n_best_gap : (r_a.neg ? GAP_MIN : GAP_MAX);
            r_o.found <= n_found;
            r_o.id    <= n_found ? n_best_id : '0;
            r_o.trig  <= n_found && n_best_trig;
        end
    end

    assign o_out_valid           = r_o_valid;
    assign o_out                 = r_o;
    assign o_status.judged_valid = r_a_valid;
    assign o_status.last_fire    = w_a_fire && r_a.last;

endmodule

// ===== src/nearest_box_along_axis.sv =====
// A result appears on the master side once the transaction of the item marked last is accepted
//   and has passed through the queue, the judged stage and the output register.
// Throughput: one item per cycle while results are taken; the running-best compare is the only feedback path.
// A 4-entry queue lets input keep flowing while a result waits on the master side.
// Reset: synchronous, active low; clears the queue, the mover and the running best.
// ---------------------------------------------------------------------------
// nearest_box_along_axis
// Finds the nearest box a moving box meets along one heading.
// ---------------------------------------------------------------------------
module nearest_box_along_axis #(
    parameter int FRAC_BITS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // center_x, center_y, scale_x, scale_y, box_x, box_y, box_id,
    // trigger_flag, is_family, heading, zero fill
    input  logic [nba_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,  // command
    input  logic                            i_s_axis_tlast,  // last_candidate
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // clearance, found, hit_id, hit_trigger, zero fill
    output logic [nba_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import nba_pkg::*;

    t_entry       w_entry, w_head;
    t_q_status    w_q_status;
    t_result      w_result;
    t_back_status w_back_status;
    logic         w_push, w_pop;
    logic         w_in_fire, w_last_fire, w_no_hit, w_hit_zero;

    nba_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_entry         (w_entry)
    );

    nba_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    nba_back #(
        .FRAC_BITS (FRAC_BITS),
        .ID_BITS   (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (w_result),
        .o_status    (w_back_status)
    );

    assign o_m_axis_tdata = {4'b0000, w_result.trig, w_result.id, w_result.found, w_result.gap};

    assign w_in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last_fire = w_back_status.last_fire;
    assign w_no_hit    = o_m_axis_tvalid && !o_m_axis_tdata[26];
    assign w_hit_zero  = (o_m_axis_tdata[42:27] == 16'd0) && !o_m_axis_tdata[43];

`include "nearest_box_along_axis_assert.svh"

    `NBA_ASSERT_NEXT(a_push_lands, w_in_fire, w_q_status.not_empty, "transaction lost")
    `NBA_ASSERT_SAME(a_res_cause, $rose(o_m_axis_tvalid), $past(w_last_fire), "stray result")
    `NBA_ASSERT_SAME(a_no_hit_clean, w_no_hit, w_hit_zero, "no hit but id or trigger set")

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_box_along_axis. Items are driven on the
// slave stream and every transaction is fed to a predictor that tracks the
// mover and the running nearest hit. Each result on the master stream is
// compared field by field with the oldest predicted hit. A directed opening
// is followed by random queries and noise, under three idling schemes.
// ---------------------------------------------------------------------------
module testbench;

    import nba_pkg::*;

    localparam int FRAC        = 8;
    localparam int RAND_ITEMS  = 700;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                       cmd;
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [SCALE_W-1:0]         sx;
        logic [SCALE_W-1:0]         sy;
        logic [SCALE_W-1:0]         bx;
        logic [SCALE_W-1:0]         by;
        logic [FIELD_ID_W-1:0]      id;
        logic                       trig;
        logic                       fam;
        logic [1:0]                 heading;
        logic                       last;
    } t_box_item;

    class nearest_hit_board;
        longint                mover_cx, mover_cy, mover_hx, mover_hy;
        logic [FIELD_ID_W-1:0] mover_id;
        logic [1:0]            mover_heading;
        longint                best_gap;
        logic [FIELD_ID_W-1:0] best_id;
        logic                  best_trig;
        logic                  best_found;
        t_result               expected_hits[$];
        int                    mismatches;

        function new();
            mover_cx = 0;
            mover_cy = 0;
            mover_hx = 0;
            mover_hy = 0;
            mover_id = '0;
            mover_heading = HEAD_RIGHT;
            mismatches = 0;
            clear_best();
        endfunction

        function void clear_best();
            best_gap = 0;
            best_id = '0;
            best_trig = 1'b0;
            best_found = 1'b0;
        endfunction

        function longint whole(longint v);
            return v / (longint'(1) << FRAC);
        endfunction

        function longint clamp_gap(longint v);
            if (v > longint'(GAP_MAX)) return longint'(GAP_MAX);
            if (v < longint'(GAP_MIN)) return longint'(GAP_MIN);
            return v;
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        function void note_box(logic [IN_TDATA_W-1:0] d, logic cmd, logic last);
            logic signed [CENTER_W-1:0] cx, cy;
            longint                     hx, hy, mc, mh, oc, oh, mpc, mph, opc, oph, gap;
            logic [FIELD_ID_W-1:0]      id;
            logic                       along_y, neg, take, overlap;
            t_result                    hit;
            cx = d[23:0];
            cy = d[47:24];
            hx = (longint'(d[63:48]) * longint'(d[95:80])) >> (FRAC + 1);
            hy = (longint'(d[79:64]) * longint'(d[111:96])) >> (FRAC + 1);
            id = d[127:112];
            if (cmd == CMD_BEGIN) begin
                mover_cx = longint'(cx);
                mover_cy = longint'(cy);
                mover_hx = hx;
                mover_hy = hy;
                mover_id = id;
                mover_heading = d[131:130];
                clear_best();
            end else if (!d[129] && id != mover_id) begin
                along_y = (mover_heading == HEAD_DOWN || mover_heading == HEAD_UP);
                neg = (mover_heading == HEAD_LEFT || mover_heading == HEAD_UP);
                mc  = along_y ? mover_cy : mover_cx;
                mh  = along_y ? mover_hy : mover_hx;
                oc  = along_y ? longint'(cy) : longint'(cx);
                oh  = along_y ? hy : hx;
                mpc = along_y ? mover_cx : mover_cy;
                mph = along_y ? mover_hx : mover_hy;
                opc = along_y ? longint'(cx) : longint'(cy);
                oph = along_y ? hx : hy;
                overlap = whole(mpc - mph) < whole(opc + oph) &&
                          whole(opc - oph) < whole(mpc + mph);
                if (overlap) begin
                    if (neg) begin
                        gap = clamp_gap((oc + oh) - (mc - mh));
                        take = gap <= 0 && (!best_found || gap > best_gap);
                    end else begin
                        gap = clamp_gap((oc - oh) - (mc + mh));
                        take = gap >= 0 && (!best_found || gap < best_gap);
                    end
                    if (take) begin
                        best_gap = gap;
                        best_id = id;
                        best_trig = d[128];
                        best_found = 1'b1;
                    end
                end
            end
            if (!last) return;
            neg = (mover_heading == HEAD_LEFT || mover_heading == HEAD_UP);
            hit.gap   = best_found ? GAP_W'(best_gap) : (neg ? GAP_MIN : GAP_MAX);
            hit.found = best_found;
            hit.id    = best_found ? best_id : '0;
            hit.trig  = best_found ? best_trig : 1'b0;
            expected_hits.push_back(hit);
            clear_best();
        endfunction

        function void check_hit(logic [OUT_TDATA_W-1:0] d);
            t_result want, got;
            got.gap   = d[25:0];
            got.found = d[26];
            got.id    = d[42:27];
            got.trig  = d[43];
            if (expected_hits.size() == 0) begin
                $display("%0t: result expected none, got gap %0d found %0b id %0d trigger %0b",
                         $time, got.gap, got.found, got.id, got.trig);
                mismatches++;
                return;
            end
            want = expected_hits.pop_front();
            if (got.gap !== want.gap) begin
                $display("%0t: clearance expected %0d, got %0d", $time, want.gap, got.gap);
                mismatches++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
                mismatches++;
            end
            if (got.id !== want.id) begin
                $display("%0t: hit_id expected %0d, got %0d", $time, want.id, got.id);
                mismatches++;
            end
            if (got.trig !== want.trig) begin
                $display("%0t: hit_trigger expected %0b, got %0b", $time, want.trig, got.trig);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // center_x, center_y, scale_x, scale_y, box_x,
                                              // box_y, box_id, trigger_flag, is_family,
                                              // heading, zero fill
    logic                   i_s_axis_tuser;   // command
    logic                   i_s_axis_tlast;   // last_candidate
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // clearance, found, hit_id, hit_trigger,
                                              // zero fill

    nearest_hit_board board;
    int               send_idle_pct;
    int               take_stall_pct;
    int               items_sent;
    int               cycles;

    nearest_box_along_axis u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= take_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                board.note_box(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                board.check_hit(o_m_axis_tdata);
            end
        end
    end

    function automatic t_box_item mk_box(logic cmd, logic [23:0] cx, logic [23:0] cy,
                                         logic [15:0] sx, logic [15:0] sy,
                                         logic [15:0] bx, logic [15:0] by,
                                         logic [15:0] id, logic trig, logic fam,
                                         logic [1:0] heading, logic last);
        t_box_item it;
        it.cmd = cmd;
        it.cx = cx;
        it.cy = cy;
        it.sx = sx;
        it.sy = sy;
        it.bx = bx;
        it.by = by;
        it.id = id;
        it.trig = trig;
        it.fam = fam;
        it.heading = heading;
        it.last = last;
        return it;
    endfunction

    function automatic logic [15:0] rand_scale();
        if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 16'h0400));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_id();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 15));
    endfunction

    task automatic send_box(input t_box_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, it.heading, it.fam, it.trig, it.id, it.by, it.bx,
                            it.sy, it.sx, it.cy, it.cx};
        i_s_axis_tuser  <= it.cmd;
        i_s_axis_tlast  <= it.last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic run_directed();
        send_box(mk_box(CMD_CAND, 24'd5000, 24'd0, 16'h0400, 16'h0400, 16'h0100, 16'h0100,
                        16'd7, 1'b0, 1'b0, HEAD_RIGHT, 1'b1));
        send_box(mk_box(CMD_CAND, 24'd3000, 24'd0, 16'h0400, 16'h0400, 16'h0100, 16'h0100,
                        16'd0, 1'b1, 1'b0, HEAD_RIGHT, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 1'b1, 1'b1, HEAD_RIGHT, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h800000, 24'h7FFFFF, 16'h0000, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 1'b0, 1'b0, HEAD_LEFT, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h0, 24'h0, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF,
                        16'h1234, 1'b1, 1'b0, HEAD_DOWN, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h1, 24'hFFFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0,
                        16'h4321, 1'b0, 1'b1, HEAD_UP, 1'b1));
        // right query: self, family, trigger far, nearer, tie, behind, off axis, touching
        send_box(mk_box(CMD_BEGIN, 24'h0, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd5, 1'b0, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h1000, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd5, 1'b0, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0800, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd9, 1'b0, 1'b1, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h2000, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd10, 1'b1, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0C00, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd11, 1'b0, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0C00, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd12, 1'b1, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, -24'sh0800, 24'h0, 16'h0100, 16'h0100, 16'h0200,
                        16'h0200, 16'd13, 1'b0, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0400, 24'h0200, 16'h0100, 16'h0100, 16'h0200,
                        16'h0200, 16'd15, 1'b0, 1'b0, HEAD_RIGHT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0200, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd14, 1'b1, 1'b0, HEAD_RIGHT, 1'b1));
        // new search against the same mover
        send_box(mk_box(CMD_CAND, 24'h0600, 24'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd16, 1'b0, 1'b0, HEAD_LEFT, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h0, 24'h1000, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd20, 1'b0, 1'b0, HEAD_UP, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0, 24'h0800, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd21, 1'b1, 1'b0, HEAD_DOWN, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h0, 24'h1000, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd22, 1'b0, 1'b0, HEAD_DOWN, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h0, 24'h0800, 16'h0100, 16'h0100, 16'h0200, 16'h0200,
                        16'd23, 1'b0, 1'b0, HEAD_UP, 1'b1));
        send_box(mk_box(CMD_BEGIN, 24'h7FFFFF, 24'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b0, 1'b0, HEAD_LEFT, 1'b0));
        send_box(mk_box(CMD_CAND, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFE, 1'b1, 1'b0, HEAD_UP, 1'b1));
    endtask

    task automatic run_random();
        int          base;
        int          n;
        logic [23:0] mx, my;
        logic [15:0] mid;
        t_box_item   it;
        base = items_sent;
        while (items_sent - base < RAND_ITEMS) begin
            case ((items_sent - base) * 3 / RAND_ITEMS)
                0: begin
                    send_idle_pct  = 17;
                    take_stall_pct = 77;
                end
                1: begin
                    send_idle_pct  = 77;
                    take_stall_pct = 17;
                end
                default: begin
                    send_idle_pct  = 0;
                    take_stall_pct = 0;
                end
            endcase
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 9) == 0) begin
                    mx = 24'($urandom);
                    my = 24'($urandom);
                end else begin
                    mx = 24'($urandom_range(0, 65535)) - 24'd32768;
                    my = 24'($urandom_range(0, 65535)) - 24'd32768;
                end
                mid = rand_id();
                n = $urandom_range(0, 8);
                send_box(mk_box(CMD_BEGIN, mx, my, rand_scale(), rand_scale(), rand_scale(),
                                rand_scale(), mid, 1'($urandom), 1'($urandom),
                                2'($urandom), n == 0));
                for (int k = 0; k < n; k++) begin
                    it = mk_box(CMD_CAND,
                                mx + 24'($urandom_range(0, 16383)) - 24'd8192,
                                my + 24'($urandom_range(0, 16383)) - 24'd8192,
                                rand_scale(), rand_scale(), rand_scale(), rand_scale(),
                                ($urandom_range(0, 99) < 8) ? mid : rand_id(),
                                1'($urandom), $urandom_range(0, 9) == 0, 2'($urandom),
                                k == n - 1);
                    send_box(it);
                end
            end else begin
                send_box(mk_box(1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
                                $urandom_range(0, 3) == 0));
            end
        end
    endtask

    initial begin
        board = new();
        send_idle_pct   = 17;
        take_stall_pct  = 77;
        items_sent      = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_BEGIN;
        i_s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/nba_pkg.sv
src/nba_front.sv
src/nba_queue.sv
src/nba_back.sv
src/nearest_box_along_axis.sv
dv/testbench.sv
